[rtl/brl_pkg.sv]
// brl_pkg: shared types and constants of the line rasterizer
// command codes and the request and pixel beat structs
// no dependencies
`timescale 1ns / 1ps

package brl_pkg;

    localparam int CoordBits = 10;
    localparam int ColorBits = 24;

    localparam logic CmdStart = 1'b0;
    localparam logic CmdStep  = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [CoordBits-1:0] start_x;
        logic [CoordBits-1:0] start_y;
        logic [CoordBits-1:0] end_x;
        logic [CoordBits-1:0] end_y;
        logic [ColorBits-1:0] color_value;
    } req_t;

    typedef struct packed {
        logic [CoordBits-1:0] pixel_x;
        logic [CoordBits-1:0] pixel_y;
        logic [ColorBits-1:0] pixel_color;
        logic                 last_pixel;
    } pix_t;

endpackage

[rtl/bresenham_line_rasterizer.sv]
// bresenham_line_rasterizer: an accepted step beat's pixel beat is registered
// throughput one beat per cycle unless stalled: the line state and the pixel output
// register are each updated in a single pass, and req_ready stays high while it drains
// a start beat gives no pixel; a step with no line in progress is taken and dropped
// reset (rst_n, async, active low) clears the line state; no line is active after reset
// depends on brl_pkg
`timescale 1ns / 1ps

module bresenham_line_rasterizer
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  brl_pkg::req_t req,
    output logic          pix_valid,
    input  logic          pix_ready,
    output brl_pkg::pix_t pix
);

    localparam int Cb      = brl_pkg::CoordBits;
    localparam int DeltaW  = Cb + 1;
    localparam int DecBits = Cb + 4;

    typedef enum logic [2:0] {
        MODE_SHALLOW_UP   = 3'd0,
        MODE_STEEP_UP     = 3'd1,
        MODE_SHALLOW_DOWN = 3'd2,
        MODE_STEEP_DOWN   = 3'd3,
        MODE_VERT_UP      = 3'd4,
        MODE_VERT_DOWN    = 3'd5
    } mode_t;

    logic [Cb-1:0]               cur_x_reg, cur_x_next;
    logic [Cb-1:0]               cur_y_reg, cur_y_next;
    logic [Cb-1:0]               stop_x_reg, stop_x_next;
    logic [Cb-1:0]               stop_y_reg, stop_y_next;
    logic signed [DeltaW-1:0]    delta_y_reg, delta_y_next;
    logic signed [DeltaW-1:0]    neg_delta_x_reg, neg_delta_x_next;
    logic signed [DecBits-1:0]   decision_reg, decision_next;
    mode_t                       mode_reg, mode_next;
    logic                        active_reg, active_next;
    logic [brl_pkg::ColorBits-1:0] color_reg, color_next;
    logic                        pix_valid_reg, pix_valid_next;
    brl_pkg::pix_t               pix_reg, pix_next;

    logic                        req_fire;
    logic                        start_fire;
    logic                        step_fire;
    logic                        last;
    logic [Cb-1:0]               xa, ya, xb, yb;
    logic [Cb-1:0]               dx_u;
    logic signed [DeltaW-1:0]    a_s;
    logic signed [DeltaW-1:0]    dx_s;
    logic signed [DeltaW-1:0]    ndx_s;
    logic signed [DecBits-1:0]   a_w, dx_w;
    logic signed [DecBits-1:0]   a2_w, b2_w;

    assign req_ready  = !pix_valid_reg || pix_ready;
    assign req_fire   = req_valid && req_ready;
    assign start_fire = req_fire && (req.cmd == brl_pkg::CmdStart);
    assign step_fire  = req_fire && (req.cmd == brl_pkg::CmdStep) && active_reg;

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

    // endpoint ordering so that x never decreases
    always_comb
    begin
        if (req.start_x > req.end_x)
        begin
            xa = req.end_x;
            ya = req.end_y;
            xb = req.start_x;
            yb = req.start_y;
        end
        else
        begin
            xa = req.start_x;
            ya = req.start_y;
            xb = req.end_x;
            yb = req.end_y;
        end
        dx_u  = xb - xa;
        a_s   = signed'({1'b0, yb}) - signed'({1'b0, ya});
        dx_s  = signed'({1'b0, dx_u});
        ndx_s = -dx_s;
        a_w   = signed'({{(DecBits-DeltaW){a_s[DeltaW-1]}}, a_s});
        dx_w  = signed'({{(DecBits-DeltaW){1'b0}}, dx_s});
    end

    // doubled deltas of the running line
    assign a2_w = signed'({{(DecBits-DeltaW-1){delta_y_reg[DeltaW-1]}}, delta_y_reg, 1'b0});
    assign b2_w = signed'({{(DecBits-DeltaW-1){neg_delta_x_reg[DeltaW-1]}},
                           neg_delta_x_reg, 1'b0});

    assign last = (mode_reg == MODE_SHALLOW_UP || mode_reg == MODE_SHALLOW_DOWN)
                  ? (cur_x_reg == stop_x_reg) : (cur_y_reg == stop_y_reg);

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        stop_x_next      = stop_x_reg;
        stop_y_next      = stop_y_reg;
        delta_y_next     = delta_y_reg;
        neg_delta_x_next = neg_delta_x_reg;
        decision_next    = decision_reg;
        mode_next        = mode_reg;
        active_next      = active_reg;
        color_next       = color_reg;
        pix_valid_next   = pix_valid_reg && !pix_ready;
        pix_next         = pix_reg;

        if (start_fire)
        begin
            cur_x_next       = xa;
            cur_y_next       = ya;
            stop_x_next      = xb;
            stop_y_next      = yb;
            delta_y_next     = a_s;
            neg_delta_x_next = ndx_s;
            color_next       = req.color_value;
            active_next      = 1'b1;
            priority if (dx_u == '0)
            begin
                mode_next     = a_s[DeltaW-1] ? MODE_VERT_DOWN : MODE_VERT_UP;
                decision_next = '0;
            end
            else if (!a_s[DeltaW-1] && a_s <= dx_s)
            begin
                mode_next     = MODE_SHALLOW_UP;
                decision_next = (a_w <<< 1) - dx_w;
            end
            else if (a_s > dx_s)
            begin
                mode_next     = MODE_STEEP_UP;
                decision_next = a_w - (dx_w <<< 1);
            end
            else if (a_s >= ndx_s)
            begin
                mode_next     = MODE_SHALLOW_DOWN;
                decision_next = (a_w <<< 1) + dx_w;
            end
            else
            begin
                mode_next     = MODE_STEEP_DOWN;
                decision_next = a_w + (dx_w <<< 1);
            end
        end
        else if (step_fire)
        begin
            pix_valid_next       = 1'b1;
            pix_next.pixel_x     = cur_x_reg;
            pix_next.pixel_y     = cur_y_reg;
            pix_next.pixel_color = color_reg;
            pix_next.last_pixel  = last;
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_SHALLOW_UP:
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        if (decision_reg > 0)
                        begin
                            cur_y_next    = cur_y_reg + 1'b1;
                            decision_next = decision_reg + b2_w + a2_w;
                        end
                        else
                            decision_next = decision_reg + a2_w;
                    end
                    MODE_STEEP_UP:
                    begin
                        cur_y_next = cur_y_reg + 1'b1;
                        if (decision_reg < 0)
                        begin
                            cur_x_next    = cur_x_reg + 1'b1;
                            decision_next = decision_reg + a2_w + b2_w;
                        end
                        else
                            decision_next = decision_reg + b2_w;
                    end
                    MODE_SHALLOW_DOWN:
                    begin
                        cur_x_next = cur_x_reg + 1'b1;
                        if (decision_reg < 0)
                        begin
                            cur_y_next    = cur_y_reg - 1'b1;
                            decision_next = decision_reg - b2_w + a2_w;
                        end
                        else
                            decision_next = decision_reg + a2_w;
                    end
                    MODE_STEEP_DOWN:
                    begin
                        cur_y_next = cur_y_reg - 1'b1;
                        if (decision_reg > 0)
                        begin
                            cur_x_next    = cur_x_reg + 1'b1;
                            decision_next = decision_reg + a2_w - b2_w;
                        end
                        else
                            decision_next = decision_reg - b2_w;
                    end
                    MODE_VERT_UP:
                        cur_y_next = cur_y_reg + 1'b1;
                    default:
                        cur_y_next = cur_y_reg - 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            stop_x_reg      <= '0;
            stop_y_reg      <= '0;
            delta_y_reg     <= '0;
            neg_delta_x_reg <= '0;
            decision_reg    <= '0;
            mode_reg        <= MODE_SHALLOW_UP;
            active_reg      <= 1'b0;
            color_reg       <= '0;
            pix_valid_reg   <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            stop_x_reg      <= stop_x_next;
            stop_y_reg      <= stop_y_next;
            delta_y_reg     <= delta_y_next;
            neg_delta_x_reg <= neg_delta_x_next;
            decision_reg    <= decision_next;
            mode_reg        <= mode_next;
            active_reg      <= active_next;
            color_reg       <= color_next;
            pix_valid_reg   <= pix_valid_next;
        end
    end

    // pixel payload holds no control state
    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
    end

endmodule

[rtl/brl_checker.sv]
// brl_checker: port-level assertions for the line rasterizer
// bound to bresenham_line_rasterizer; depends on brl_pkg
`timescale 1ns / 1ps

module brl_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input brl_pkg::req_t req,
    input logic          pix_valid,
    input logic          pix_ready,
    input brl_pkg::pix_t pix
);

    // a pending pixel beat stays up until taken
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
        else $error("pixel beat dropped while stalled");

    a_pix_stable: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> $stable(pix))
        else $error("pixel payload changed while stalled");

    // an empty output register never blocks the request side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pix_valid |-> req_ready)
        else $error("request stalled with empty output");

    // a start beat yields no pixel
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && req.cmd == brl_pkg::CmdStart |=> !pix_valid)
        else $error("pixel produced by start beat");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
);
